FILE: rtl/rbc_pkg.sv
// Shared constants and types of the byte run-length compressor.
// No dependencies; the top level, rbc_win and rbc_emit refer to it by scoped names.
package rbc_pkg;

  localparam int MAX_LITERAL = 32;  // literal block limit, 1 .. 40
  localparam int MIN_RUN     = 4;   // equal bytes that open a run, 2 .. 6

  localparam int LIT_AW  = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int LIT_CW  = $clog2(MAX_LITERAL + 1);
  localparam int WIN_AW  = $clog2(MIN_RUN);
  localparam int WIN_CW  = $clog2(MIN_RUN + 1);

  localparam logic [31:0] RUN_CAP = 32'hFFFF_FFFF;

  // Sequencer to output unit
  typedef struct packed {
    logic       push;   // queue one code byte
    logic       flush;  // close the item: send the held byte with burst end
    logic       last;   // flush marks the end of the stream
    logic [7:0] data;
  } emit_cmd_t;

  // Output unit to sequencer
  typedef struct packed {
    logic ok;       // push or flush is taken this cycle
    logic pend_v;   // a byte is held back
  } emit_sts_t;

  // Lookahead window to sequencer
  typedef struct packed {
    logic [7:0]        head;
    logic [WIN_CW-1:0] cnt;
    logic              is_run;
  } win_sts_t;

endpackage

FILE: rtl/rle_byte_compressor.sv
// Top level of the byte run-length compressor with literal blocks.
// Depends on rbc_pkg, rbc_win, rbc_emit and rbc_ram.
//
// Usage:
//   in_*  channel: one raw byte per item in in_tdata, in_tlast marks the last
//         byte of a stream. out_* channel: one compressed byte per item in
//         out_tdata; out_tuser[0] flags the last byte caused by an input item,
//         out_tlast flags the last compressed byte of the stream.
//   A run is sent as a 32-bit little-endian count and the byte; a literal block
//   as a zero word, a 32-bit little-endian count and the stored bytes.
//   Timing: a byte is taken in ST_IDLE, then a sequencer decides the window,
//   one decision per cycle, and sends each code byte through one shared output
//   unit at one byte a cycle while out_tready allows; each stored literal byte
//   first waits in ST_LIT_RD for the registered read of the literal RAM.
//   in_tready is low from the time a byte is taken until its item closes.
//   The newest code byte is held back one slot, so the output shows the first
//   byte one code byte later; the held byte leaves when the item closes.
//   Reset: window empty, no record open, output empty; no clearing pass.
//   Stall: while out_tready is low the sequencer holds on the pending byte.
module rle_byte_compressor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] raw_byte
  input  logic       in_tlast,    // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] code_byte
  output logic [0:0] out_tuser,   // [0] burst_end
  output logic       out_tlast    // stream_end
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_STEP     = 3'd1;
  localparam logic [2:0] ST_RUN_CNT  = 3'd2;
  localparam logic [2:0] ST_RUN_VAL  = 3'd3;
  localparam logic [2:0] ST_LIT_ZERO = 3'd4;
  localparam logic [2:0] ST_LIT_CNT  = 3'd5;
  localparam logic [2:0] ST_LIT_RD   = 3'd6;
  localparam logic [2:0] ST_LIT_DATA = 3'd7;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_LIT  = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 mode_r, mode_nxt;
  logic [7:0]                 run_val_r, run_val_nxt;
  logic [31:0]                run_len_r, run_len_nxt;
  logic [rbc_pkg::LIT_CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic [rbc_pkg::LIT_CW-1:0] rd_k_r, rd_k_nxt;
  logic [1:0]                 bidx_r, bidx_nxt;
  logic                       fin_r, fin_nxt;

  rbc_pkg::win_sts_t          win_sts;
  rbc_pkg::emit_cmd_t         emit_cmd;
  rbc_pkg::emit_sts_t         emit_sts;
  logic                       win_push, win_pop, win_clear;
  logic                       ram_we;
  logic [7:0]                 ram_rdata;
  logic                       decide;
  logic [31:0]                cnt_word;

  assign in_tready = (state_r == ST_IDLE);
  assign win_push  = in_tvalid && in_tready;
  assign cnt_word  = {{(32 - rbc_pkg::LIT_CW){1'b0}}, lit_cnt_r};
  assign decide    = (win_sts.cnt == rbc_pkg::WIN_CW'(rbc_pkg::MIN_RUN)) ||
                     (fin_r && (win_sts.cnt != '0));

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    run_val_nxt   = run_val_r;
    run_len_nxt   = run_len_r;
    lit_cnt_nxt   = lit_cnt_r;
    rd_k_nxt      = rd_k_r;
    bidx_nxt      = bidx_r;
    fin_nxt       = fin_r;
    win_pop       = 1'b0;
    win_clear     = 1'b0;
    ram_we        = 1'b0;
    emit_cmd      = '0;
    emit_cmd.last = fin_r;

    unique case (state_r)
      ST_IDLE: begin
        if (win_push) begin
          fin_nxt   = in_tlast;
          state_nxt = ST_STEP;
        end
      end

      ST_STEP: begin
        bidx_nxt = '0;
        if (decide) begin
          unique case (mode_r)
            MODE_RUN: begin
              if ((win_sts.head == run_val_r) && (run_len_r != rbc_pkg::RUN_CAP)) begin
                run_len_nxt = run_len_r + 32'd1;
                win_pop     = 1'b1;
              end else begin
                mode_nxt  = MODE_IDLE;
                state_nxt = ST_RUN_CNT;
              end
            end
            MODE_LIT: begin
              if ((lit_cnt_r >= rbc_pkg::LIT_CW'(rbc_pkg::MAX_LITERAL)) || win_sts.is_run) begin
                mode_nxt  = MODE_IDLE;
                state_nxt = ST_LIT_ZERO;
              end else begin
                ram_we      = 1'b1;
                lit_cnt_nxt = lit_cnt_r + rbc_pkg::LIT_CW'(1);
                win_pop     = 1'b1;
              end
            end
            default: begin
              if (win_sts.is_run) begin
                mode_nxt    = MODE_RUN;
                run_val_nxt = win_sts.head;
                run_len_nxt = 32'd1;
                win_pop     = 1'b1;
              end else begin
                mode_nxt    = MODE_LIT;
                lit_cnt_nxt = '0;
              end
            end
          endcase
        end else if (fin_r && (mode_r == MODE_RUN)) begin
          // stream end: send the open run
          mode_nxt  = MODE_IDLE;
          state_nxt = ST_RUN_CNT;
        end else if (fin_r && (mode_r == MODE_LIT)) begin
          mode_nxt  = MODE_IDLE;
          state_nxt = ST_LIT_ZERO;
        end else begin
          // close the item: release the held byte with its burst flag
          emit_cmd.flush = 1'b1;
          if (emit_sts.ok) begin
            if (fin_r) begin
              win_clear   = 1'b1;
              mode_nxt    = MODE_IDLE;
              run_len_nxt = '0;
              lit_cnt_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RUN_CNT: begin
        emit_cmd.push = 1'b1;
        emit_cmd.data = run_len_r[{bidx_r, 3'b000} +: 8];
        if (emit_sts.ok) begin
          bidx_nxt = bidx_r + 2'd1;
          if (bidx_r == 2'd3) begin
            state_nxt = ST_RUN_VAL;
          end
        end
      end

      ST_RUN_VAL: begin
        emit_cmd.push = 1'b1;
        emit_cmd.data = run_val_r;
        if (emit_sts.ok) begin
          state_nxt = ST_STEP;
        end
      end

      ST_LIT_ZERO: begin
        emit_cmd.push = 1'b1;
        emit_cmd.data = 8'h00;
        if (emit_sts.ok) begin
          bidx_nxt = bidx_r + 2'd1;
          if (bidx_r == 2'd3) begin
            state_nxt = ST_LIT_CNT;
          end
        end
      end

      ST_LIT_CNT: begin
        emit_cmd.push = 1'b1;
        emit_cmd.data = cnt_word[{bidx_r, 3'b000} +: 8];
        if (emit_sts.ok) begin
          bidx_nxt = bidx_r + 2'd1;
          rd_k_nxt = '0;
          if (bidx_r == 2'd3) begin
            state_nxt = (lit_cnt_r == '0) ? ST_STEP : ST_LIT_RD;
          end
        end
      end

      ST_LIT_RD: begin
        // wait for the registered read of entry rd_k_r
        state_nxt = ST_LIT_DATA;
      end

      ST_LIT_DATA: begin
        emit_cmd.push = 1'b1;
        emit_cmd.data = ram_rdata;
        if (emit_sts.ok) begin
          if ((rd_k_r + rbc_pkg::LIT_CW'(1)) == lit_cnt_r) begin
            state_nxt = ST_STEP;
          end else begin
            rd_k_nxt  = rd_k_r + rbc_pkg::LIT_CW'(1);
            state_nxt = ST_LIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_IDLE;
      run_len_r <= '0;
      lit_cnt_r <= '0;
      rd_k_r    <= '0;
      bidx_r    <= '0;
      fin_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      run_len_r <= run_len_nxt;
      lit_cnt_r <= lit_cnt_nxt;
      rd_k_r    <= rd_k_nxt;
      bidx_r    <= bidx_nxt;
      fin_r     <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_val_r <= run_val_nxt;
  end

  rbc_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (win_push),
    .push_byte (in_tdata),
    .pop       (win_pop),
    .clear     (win_clear),
    .sts       (win_sts)
  );

  rbc_ram #(
    .WIDTH (8),
    .DEPTH (rbc_pkg::MAX_LITERAL)
  ) u_lit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lit_cnt_r[rbc_pkg::LIT_AW-1:0]),
    .wdata (win_sts.head),
    .raddr (rd_k_r[rbc_pkg::LIT_AW-1:0]),
    .rdata (ram_rdata)
  );

  rbc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (emit_cmd),
    .sts        (emit_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // No byte is held back while waiting for the next input item.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !emit_sts.pend_v)
    else $error("held code byte left over at idle");

  // The window always has room for the next byte when input is open.
  a_idle_win_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (win_sts.cnt < rbc_pkg::WIN_CW'(rbc_pkg::MIN_RUN)))
    else $error("lookahead window full at idle");

  // The literal block never grows beyond its limit.
  a_lit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    lit_cnt_r <= rbc_pkg::LIT_CW'(rbc_pkg::MAX_LITERAL))
    else $error("literal count beyond limit");

  // A stream end clears the window and closes every record.
  a_stream_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (win_clear && state_r == ST_STEP) |=> (win_sts.cnt == '0) && (mode_r == MODE_IDLE))
    else $error("state not cleared after stream end");

  // A literal send reads only entries that were written for the open block.
  a_read_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIT_RD) |-> (rd_k_r < lit_cnt_r))
    else $error("literal read beyond the open block");

endmodule

FILE: rtl/rbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rbc_win.sv
// Lookahead window of undecided bytes: push at the tail, pop at the head.
// Depends on rbc_pkg.
module rbc_win (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        push_byte,
  input  logic              pop,
  input  logic              clear,
  output rbc_pkg::win_sts_t sts
);

  logic [7:0]                 win_r   [rbc_pkg::MIN_RUN];
  logic [7:0]                 win_nxt [rbc_pkg::MIN_RUN];
  logic [rbc_pkg::WIN_CW-1:0] cnt_r, cnt_nxt;
  logic                       all_eq;

  always_comb begin
    for (int k = 0; k < rbc_pkg::MIN_RUN; k++) begin
      win_nxt[k] = win_r[k];
    end
    cnt_nxt = cnt_r;
    if (clear) begin
      cnt_nxt = '0;
    end else if (push) begin
      win_nxt[cnt_r[rbc_pkg::WIN_AW-1:0]] = push_byte;
      cnt_nxt = cnt_r + rbc_pkg::WIN_CW'(1);
    end else if (pop) begin
      // shift toward the head
      for (int k = 0; k < rbc_pkg::MIN_RUN - 1; k++) begin
        win_nxt[k] = win_r[k + 1];
      end
      cnt_nxt = cnt_r - rbc_pkg::WIN_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < rbc_pkg::MIN_RUN; k++) begin
      win_r[k] <= win_nxt[k];
    end
  end

  always_comb begin
    all_eq = 1'b1;
    for (int k = 1; k < rbc_pkg::MIN_RUN; k++) begin
      if (win_r[k] != win_r[0]) begin
        all_eq = 1'b0;
      end
    end
  end

  assign sts.head   = win_r[0];
  assign sts.cnt    = cnt_r;
  assign sts.is_run = (cnt_r == rbc_pkg::WIN_CW'(rbc_pkg::MIN_RUN)) && all_eq;

endmodule

FILE: rtl/rbc_emit.sv
// Shared output unit: holds the newest code byte back one slot so that the
// last byte of an item can carry its burst flag, then drives the out channel.
// Depends on rbc_pkg.
module rbc_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  rbc_pkg::emit_cmd_t cmd,
  output rbc_pkg::emit_sts_t sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,   // [7:0] code_byte
  output logic [0:0]         out_tuser,   // [0] burst_end
  output logic               out_tlast    // stream_end
);

  logic       pend_v_r, pend_v_nxt;
  logic [7:0] pend_b_r, pend_b_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_b_r, out_b_nxt;
  logic       out_be_r, out_be_nxt;
  logic       out_se_r, out_se_nxt;
  logic       out_free;
  logic       ok;

  always_comb begin
    out_free   = !out_v_r || out_tready;
    ok         = !pend_v_r || out_free;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_b_nxt  = out_b_r;
    out_be_nxt = out_be_r;
    out_se_nxt = out_se_r;
    if (cmd.push && ok) begin
      if (pend_v_r) begin
        out_v_nxt  = 1'b1;
        out_b_nxt  = pend_b_r;
        out_be_nxt = 1'b0;
        out_se_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_b_nxt = cmd.data;
    end else if (cmd.flush && ok && pend_v_r) begin
      out_v_nxt  = 1'b1;
      out_b_nxt  = pend_b_r;
      out_be_nxt = 1'b1;
      out_se_nxt = cmd.last;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_b_r <= pend_b_nxt;
    out_b_r  <= out_b_nxt;
    out_be_r <= out_be_nxt;
    out_se_r <= out_se_nxt;
  end

  assign sts.ok     = ok;
  assign sts.pend_v = pend_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_b_r;
  assign out_tuser  = out_be_r;
  assign out_tlast  = out_se_r;

endmodule
